// ----- rtl/line_edit_receive_buffer_defines.svh -----
// ----------------------------------------------------------------------------
// line edit receive buffer: assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_RECEIVE_BUFFER_DEFINES_SVH
`define LINE_EDIT_RECEIVE_BUFFER_DEFINES_SVH

// same-cycle implication
`define LERB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LERB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lerb_pkg.sv -----
// ----------------------------------------------------------------------------
// lerb_pkg
// types and fixed codes of the line edit receive buffer
// ----------------------------------------------------------------------------
`default_nettype none

package lerb_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 7;

    // character codes
    localparam logic [BYTE_W-1:0] CODE_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CODE_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CODE_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] ECHO_ERASE = 8'h7F;

    // input action codes
    localparam logic ACTION_RX   = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_TERM  = 2'd0,
        OP_ERASE = 2'd1,
        OP_PLAIN = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ECHO      = 2'd0,
        KIND_LINE      = 2'd1,
        KIND_EMPTY     = 2'd2,
        KIND_NOT_READY = 2'd3
    } t_kind;

endpackage

`default_nettype wire

// ----- rtl/lerb_front.sv -----
// ----------------------------------------------------------------------------
// lerb_front
// accepts input items, classifies them into commands and holds one command
// until the queue takes it
// ----------------------------------------------------------------------------
`default_nettype none

module lerb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_action,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output lerb_pkg::t_cmd     o_cmd
);
    import lerb_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // classify by action and code
    always_comb begin
        n_cmd.data = i_rx_byte;
        if (i_action == ACTION_READ) begin
            n_cmd.op = OP_READ;
        end else if (i_rx_byte == CODE_CR || i_rx_byte == CODE_LF) begin
            n_cmd.op = OP_TERM;
        end else if (i_rx_byte == CODE_BS || i_rx_byte == CODE_DEL) begin
            n_cmd.op = OP_ERASE;
        end else begin
            n_cmd.op = OP_PLAIN;
        end
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
                r_cmd   <= n_cmd;
            end else if (i_cmd_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lerb_queue.sv -----
// ----------------------------------------------------------------------------
// lerb_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module lerb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire lerb_pkg::t_cmd i_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output lerb_pkg::t_cmd     o_cmd
);
    import lerb_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_cmd        = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lerb_back.sv -----
// ----------------------------------------------------------------------------
// lerb_back
// carries out commands: edits the character store, tracks the line flag,
// drains a line and drives the registered result
// ----------------------------------------------------------------------------
`default_nettype none

module lerb_back #(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  wire lerb_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output lerb_pkg::t_kind     o_kind,
    output logic [7:0]          o_out_byte,
    output logic                o_last,
    output logic [6:0]          o_line_count
);
    import lerb_pkg::*;

    localparam int unsigned IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int unsigned FILL_W = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned SUM_W  = FILL_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ERASE2,
        S_DRAIN
    } t_state;

    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    t_state             r_state,  n_state;
    logic [IDX_W-1:0]   r_oldest, n_oldest;
    logic [FILL_W-1:0]  r_fill,   n_fill;
    logic               r_line_ready, n_line_ready;
    logic [IDX_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]  r_cnt,    n_cnt;
    logic [BYTE_W-1:0]  r_erase,  n_erase;

    logic               r_out_valid, n_out_valid;
    t_kind              r_kind,   n_kind;
    logic [BYTE_W-1:0]  r_byte,   n_byte;
    logic               r_last,   n_last;
    logic [COUNT_W-1:0] r_count,  n_count;

    logic               can_load;
    logic               mem_we;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [SUM_W-1:0]   wr_sum;
    logic [IDX_W-1:0]   wr_pos;
    logic [IDX_W-1:0]   ptr_inc;
    logic [FILL_W-1:0]  cnt_inc;
    logic               drain_last;

    assign can_load   = !r_out_valid || i_ready;
    assign wr_sum     = SUM_W'(r_oldest) + SUM_W'(r_fill);
    assign wr_pos     = (wr_sum >= SUM_W'(BUFFER_DEPTH))
                        ? IDX_W'(wr_sum - SUM_W'(BUFFER_DEPTH)) : IDX_W'(wr_sum);
    assign ptr_inc    = (r_rd_ptr == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign cnt_inc    = r_cnt + 1'b1;
    assign drain_last = (cnt_inc == r_fill);

    always_comb begin
        n_state      = r_state;
        n_oldest     = r_oldest;
        n_fill       = r_fill;
        n_line_ready = r_line_ready;
        n_rd_ptr     = r_rd_ptr;
        n_cnt        = r_cnt;
        n_erase      = r_erase;
        n_out_valid  = r_out_valid && !i_ready;
        n_kind       = r_kind;
        n_byte       = r_byte;
        n_last       = r_last;
        n_count      = r_count;
        o_cmd_ready  = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_rd_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && can_load) begin
                    o_cmd_ready = 1'b1;
                    n_kind      = KIND_ECHO;
                    n_byte      = i_cmd.data;
                    n_last      = 1'b1;
                    n_count     = '0;
                    n_out_valid = 1'b1;
                    case (i_cmd.op)
                        OP_TERM: begin
                            n_line_ready = 1'b1;
                        end
                        OP_ERASE: begin
                            n_byte = ECHO_ERASE;
                            if (r_fill != '0) begin
                                n_fill  = r_fill - 1'b1;
                                n_last  = 1'b0;
                                n_erase = i_cmd.data;
                                n_state = S_ERASE2;
                            end
                        end
                        OP_PLAIN: begin
                            if (r_fill != FILL_W'(BUFFER_DEPTH)) begin
                                mem_we = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        OP_READ: begin
                            n_byte = '0;
                            if (!r_line_ready) begin
                                n_kind = KIND_NOT_READY;
                            end else if (r_fill == '0) begin
                                n_kind       = KIND_EMPTY;
                                n_line_ready = 1'b0;
                            end else begin
                                // first store read now, result follows from the drain
                                n_out_valid  = r_out_valid && !i_ready;
                                n_kind       = r_kind;
                                n_byte       = r_byte;
                                n_last       = r_last;
                                n_count      = r_count;
                                n_line_ready = 1'b0;
                                rd_en        = 1'b1;
                                rd_addr      = r_oldest;
                                n_rd_ptr     = r_oldest;
                                n_cnt        = '0;
                                n_state      = S_DRAIN;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !i_ready;
                        end
                    endcase
                end
            end
            S_ERASE2: begin
                if (can_load) begin
                    n_kind      = KIND_ECHO;
                    n_byte      = r_erase;
                    n_last      = 1'b1;
                    n_count     = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (can_load) begin
                    n_kind      = KIND_LINE;
                    n_byte      = r_rd_data;
                    n_last      = drain_last;
                    n_count     = COUNT_W'(cnt_inc);
                    n_out_valid = 1'b1;
                    if (drain_last) begin
                        n_oldest = ptr_inc;
                        n_fill   = '0;
                        n_state  = S_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_inc;
                        n_rd_ptr = ptr_inc;
                        n_cnt    = cnt_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // character store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_pos] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_oldest     <= '0;
            r_fill       <= '0;
            r_line_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_oldest     <= n_oldest;
            r_fill       <= n_fill;
            r_line_ready <= n_line_ready;
            r_out_valid  <= n_out_valid;
            r_rd_ptr     <= n_rd_ptr;
            r_cnt        <= n_cnt;
            r_erase      <= n_erase;
            r_kind       <= n_kind;
            r_byte       <= n_byte;
            r_last       <= n_last;
            r_count      <= n_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_byte;
    assign o_last       = r_last;
    assign o_line_count = r_count;

endmodule

`default_nettype wire

// ----- rtl/line_edit_receive_buffer.sv -----
// ----------------------------------------------------------------------------
// line_edit_receive_buffer
// receive buffer with terminal line editing: echoes received bytes, applies
// erase codes, and hands out a completed line on a read request
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_ready  i_action, i_rx_byte
//  result    out        o_valid / i_ready  o_kind, o_out_byte, o_last, o_line_count
//
//  a received byte or a plain read passes the front register, a queue slot and
//  the result register before its first result; an erase gives its second echo
//  from a separate erase state; a line read first reads the store, then gives
//  one line byte per cycle while results are taken, through the single read port
//  of the character store; front, queue and result register let input transfers
//  go on while results stall; reset is synchronous and active low; the character
//  store is not cleared, only the state, result valid, fill level, oldest index and line flag
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_edit_receive_buffer_defines.svh"

module line_edit_receive_buffer #(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_action,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic [6:0]      o_line_count
);
    import lerb_pkg::*;

    // front to queue
    logic  front_valid;
    logic  front_ready;
    t_cmd  front_cmd;

    // queue to back
    logic  queue_valid;
    logic  queue_ready;
    t_cmd  queue_cmd;

    t_kind back_kind;

    // classifies each input transfer into a command
    lerb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    // decouples the front from a back stalled on the result side
    lerb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_cmd        (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_cmd        (queue_cmd)
    );

    // store, line flag, drain sequencing and result register
    lerb_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (queue_valid),
        .o_cmd_ready  (queue_ready),
        .i_cmd        (queue_cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (back_kind),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_line_count (o_line_count)
    );

    assign o_kind = back_kind;

    // only line bytes carry a count
    `LERB_ASSERT_NOW(a_count_only_on_line, i_clk, i_rst_n, o_valid && (back_kind != KIND_LINE), o_line_count == '0, "line count on a result that is not a line byte")

    // empty and not-ready reports are single, zero-byte results
    `LERB_ASSERT_NOW(a_report_single, i_clk, i_rst_n, o_valid && (back_kind == KIND_EMPTY || back_kind == KIND_NOT_READY), o_last && (o_out_byte == '0), "status report not a lone zero result")

    // a drain delivers the next line byte straight after each transfer
    `LERB_ASSERT_NEXT(a_drain_continues, i_clk, i_rst_n, o_valid && i_ready && (back_kind == KIND_LINE) && !o_last, o_valid && (back_kind == KIND_LINE) && (o_line_count == 7'($past(o_line_count) + 7'd1)), "line drain broke off or miscounted")

endmodule

`default_nettype wire

// ----- bench/line_edit_receive_buffer_tb.sv -----
// ----------------------------------------------------------------------------
// line_edit_receive_buffer_tb
// self-checking bench for the line edit receive buffer: a queue-fed driver
// offers received bytes and read requests, a behavioural line editor predicts
// every echo and line byte, and a monitor compares each result transfer
// ----------------------------------------------------------------------------
`default_nettype none

module line_edit_receive_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lerb_pkg::*;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 110;

    // one input transfer as queued for the driver
    typedef struct {
        logic       action;
        logic [7:0] code;
    } t_line_input;

    // one result transfer as predicted
    typedef struct {
        t_kind      kind;
        logic [7:0] code;
        logic       is_last;
        logic [6:0] cnt;
    } t_line_result;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic       i_action  = ACTION_RX;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_last;
    logic [6:0] o_line_count;

    t_line_input  pending_inputs[$];
    t_line_result due_results[$];

    // predicted editor state
    logic [7:0] line_store [DEPTH];
    logic [5:0] head_idx     = '0;
    logic [6:0] stored_count = '0;
    bit         line_flag    = 1'b0;

    int unsigned send_gap_pct   = 0;
    int unsigned accept_gap_pct = 0;
    int unsigned error_count    = 0;
    int unsigned queued_items   = 0;
    bit          took           = 1'b0;
    bit          hold_go        = 1'b0;
    bit          rx_hold        = 1'b0;

    line_edit_receive_buffer #(
        .BUFFER_DEPTH (DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_line_count (o_line_count)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic expect_result(input t_kind kind, input logic [7:0] code,
                                 input logic is_last, input logic [6:0] cnt);
        t_line_result r;
        r.kind    = kind;
        r.code    = code;
        r.is_last = is_last;
        r.cnt     = cnt;
        due_results.push_back(r);
    endtask

    // line editor: works out the results of one accepted transfer
    task automatic edit_line(input logic action, input logic [7:0] code);
        int unsigned n;
        logic [5:0]  slot;
        if (action == ACTION_READ) begin
            if (!line_flag) begin
                expect_result(KIND_NOT_READY, 8'h00, 1'b1, 7'd0);
            end else begin
                line_flag = 1'b0;
                n = stored_count;
                if (n == 0) begin
                    expect_result(KIND_EMPTY, 8'h00, 1'b1, 7'd0);
                end else begin
                    // whole line goes out oldest first, the store index wraps
                    for (int k = 0; k < n; k++) begin
                        slot = head_idx + 6'(k);
                        expect_result(KIND_LINE, line_store[slot], (k + 1 == n), 7'(k + 1));
                    end
                    head_idx     = head_idx + 6'(n);
                    stored_count = '0;
                end
            end
        end else if (code == CODE_CR || code == CODE_LF) begin
            // terminators are echoed but never stored
            line_flag = 1'b1;
            expect_result(KIND_ECHO, code, 1'b1, 7'd0);
        end else if (code == CODE_BS || code == CODE_DEL) begin
            if (stored_count > 0) begin
                stored_count--;
                expect_result(KIND_ECHO, ECHO_ERASE, 1'b0, 7'd0);
                expect_result(KIND_ECHO, code, 1'b1, 7'd0);
            end else begin
                expect_result(KIND_ECHO, ECHO_ERASE, 1'b1, 7'd0);
            end
        end else begin
            // a full buffer drops the byte but still echoes it
            if (stored_count < DEPTH) begin
                slot             = head_idx + stored_count[5:0];
                line_store[slot] = code;
                stored_count++;
            end
            expect_result(KIND_ECHO, code, 1'b1, 7'd0);
        end
    endtask

    // monitor: tracks input transfers for prediction and checks result transfers
    always @(posedge i_clk) begin
        t_line_result want;
        took = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                edit_line(i_action, i_rx_byte);
                took = 1'b1;
            end
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                            o_kind, o_out_byte));
                end else begin
                    want = due_results.pop_front();
                    if (o_kind !== want.kind || o_out_byte !== want.code ||
                        o_last !== want.is_last || o_line_count !== want.cnt) begin
                        flag_mismatch($sformatf(
                            "got kind %0d byte %02h last %0b count %0d, want %0d %02h %0b %0d",
                            o_kind, o_out_byte, o_last, o_line_count,
                            want.kind, want.code, want.is_last, want.cnt));
                    end
                end
            end
        end
    end

    // driver: valid holds with a steady payload until the transfer
    always @(negedge i_clk) begin
        t_line_input item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || took) begin
            if (pending_inputs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                item = pending_inputs.pop_front();
                i_valid   <= 1'b1;
                i_action  <= item.action;
                i_rx_byte <= item.code;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !rx_hold && ($urandom_range(99) >= accept_gap_pct);
        end
    end

    // long receiver hold-off, counted in cycles here so the buffer backs up
    initial begin
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic push_rx(input logic [7:0] code);
        t_line_input item;
        item.action = ACTION_RX;
        item.code   = code;
        pending_inputs.push_back(item);
        queued_items++;
    endtask

    // rx_byte is don't-care on a read, so it is randomised
    task automatic push_read();
        t_line_input item;
        item.action = ACTION_READ;
        item.code   = 8'($urandom_range(255));
        pending_inputs.push_back(item);
        queued_items++;
    endtask

    function automatic logic [7:0] plain_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == CODE_CR || c == CODE_LF || c == CODE_BS || c == CODE_DEL);
        return c;
    endfunction

    // a typed line with the odd erase, a terminator, and usually a read
    task automatic queue_line(input int unsigned max_len);
        int unsigned len;
        len = $urandom_range(max_len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
                push_rx($urandom_range(1) ? CODE_BS : CODE_DEL);
            end else begin
                push_rx(plain_code());
            end
        end
        push_rx($urandom_range(1) ? CODE_CR : CODE_LF);
        if ($urandom_range(3) != 0) begin
            push_read();
        end
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_inputs.size() != 0 || i_valid || due_results.size() != 0);
    endtask

    task automatic run_random_phase(input int unsigned send_pct, input int unsigned accept_pct);
        int unsigned goal;
        @(posedge i_clk);
        send_gap_pct   = send_pct;
        accept_gap_pct = accept_pct;
        goal           = queued_items + PHASE_ITEMS;
        while (queued_items < goal) begin
            if ($urandom_range(4) != 0) begin
                // mostly short lines, now and then one that overfills the buffer
                queue_line(($urandom_range(24) == 0) ? DEPTH + 6 : 12);
            end else if ($urandom_range(1) != 0) begin
                push_rx(8'($urandom_range(255)));
            end else begin
                push_read();
            end
        end
        wait_drained();
    endtask

    // stimulus
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every kind of result and editing corner
        push_read();                  // no line ready yet
        push_rx(CODE_BS);             // erase on an empty buffer
        push_rx(CODE_DEL);
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx(8'h41);
        push_rx(CODE_BS);             // erase with bytes stored
        push_rx(CODE_DEL);
        push_rx(8'h80);
        push_rx(CODE_CR);
        push_rx(8'h7E);               // typed after the terminator, joins the line
        push_read();                  // line delivered
        push_read();                  // flag cleared again
        push_rx(CODE_LF);
        push_read();                  // terminator with nothing stored
        push_rx(CODE_LF);
        push_rx(CODE_CR);
        push_rx(8'h01);
        push_read();
        push_rx(CODE_DEL);
        push_rx(CODE_LF);
        push_read();
        wait_drained();

        // back-pressure: receiver held off while a buffer's worth and more arrives
        @(posedge i_clk);
        hold_go = 1'b1;
        for (int i = 0; i < DEPTH + 4; i++) begin
            push_rx(plain_code());    // the last few are dropped on a full buffer
        end
        push_rx(CODE_CR);
        push_read();                  // a full line of DEPTH bytes
        wait_drained();

        run_random_phase(20, 60);
        run_random_phase(60, 20);
        run_random_phase(0, 0);

        // settle, then flag any predicted results that never arrived
        repeat (20) @(posedge i_clk);
        if (due_results.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
